// File: hdl/otl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package otl_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int ID_WIDTH   = 16;
  localparam int KEY_WIDTH  = 16;

  localparam int IDX_W   = $clog2(LIST_DEPTH);
  localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int FUNC_W  = 2;
  localparam int ORDER_W = 2;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // item operation codes
  localparam logic [FUNC_W-1:0] FUNC_ENTER  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXIT   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;

  // insert policy codes
  localparam logic [ORDER_W-1:0] ORDER_APPEND  = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_PREPEND = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_STRONG  = 2'd2;
  localparam logic [ORDER_W-1:0] ORDER_WEAK    = 2'd3;

  // register word index
  localparam logic [APB_AW-3:0] REG_ADD_ORDER = '0;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE
  } op_e;

  typedef struct packed {
    logic [ID_WIDTH-1:0]  id;
    logic [KEY_WIDTH-1:0] key;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    op_e                op;
    logic [ORDER_W-1:0] order;
    entry_t             item;
    logic [CNT_W-1:0]   count;
  } cmd_t;

endpackage

`default_nettype wire

// File: hdl/otl_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface otl_in_if;
  logic                            valid;
  logic                            ready;
  logic [otl_pkg::FUNC_W-1:0]      func;
  logic [otl_pkg::ID_WIDTH-1:0]    entity_id;
  logic [otl_pkg::KEY_WIDTH-1:0]   strength;
  logic                            killed;

  modport source (output valid, func, entity_id, strength, killed, input ready);
  modport sink   (input valid, func, entity_id, strength, killed, output ready);
endinterface

`default_nettype wire

// File: hdl/otl_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface otl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          target_valid;
  logic [otl_pkg::ID_WIDTH-1:0]  target_id;
  logic [otl_pkg::CNT_W-1:0]     entry_count;
  logic                          overflow;

  modport source (output valid, target_valid, target_id, entry_count, overflow,
                  input ready);
  modport sink   (input valid, target_valid, target_id, entry_count, overflow,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/otl_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module otl_cell (
  input  wire logic                      clk_i,
  input  wire logic [otl_pkg::IDX_W-1:0] idx_i,
  input  wire otl_pkg::cmd_t             cmd_i,
  input  wire logic                      seen_i,
  input  wire otl_pkg::entry_t           left_i,
  input  wire otl_pkg::entry_t           right_i,
  output logic                           seen_o,
  output otl_pkg::entry_t                entry_q_o,
  output otl_pkg::entry_t                entry_d_o
);

  otl_pkg::entry_t entry_q;
  otl_pkg::entry_t entry_d;
  logic            occ;
  logic            hit;

  assign occ = (otl_pkg::CNT_W'(idx_i) < cmd_i.count);

  // first hit along the chain marks the insert slot or the removed entry
  always_comb begin
    hit = 1'b0;
    case (cmd_i.op)
      otl_pkg::OP_INSERT: begin
        case (cmd_i.order)
          otl_pkg::ORDER_APPEND:  hit = !occ;
          otl_pkg::ORDER_PREPEND: hit = 1'b1;
          otl_pkg::ORDER_STRONG:  hit = !occ || (cmd_i.item.key > entry_q.key);
          default:                hit = !occ || (cmd_i.item.key < entry_q.key);
        endcase
      end
      otl_pkg::OP_REMOVE: hit = occ && (cmd_i.item.id == entry_q.id);
      default:            hit = 1'b0;
    endcase
  end

  assign seen_o = seen_i | hit;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      otl_pkg::OP_INSERT: begin
        if (seen_i) begin
          entry_d = left_i;
        end else if (hit) begin
          entry_d = cmd_i.item;
        end
      end
      otl_pkg::OP_REMOVE: begin
        if (seen_i || hit) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_q_o = entry_q;
  assign entry_d_o = entry_d;

endmodule

`default_nettype wire

// File: hdl/ordered_target_list_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Latency: a result is offered on the cycle after its item is accepted.
// Throughput: one item per cycle unless the result stalls; every cell updates
//   in the same cycle, so the first-hit ripple through the cells sets the path.
// Input ready stays high while the result register is empty or being drained.
// Reset clears the entry count, current target, insert policy and result
//   valid; cell storage is not cleared and is only read below the count.

module ordered_target_list_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  otl_in_if.sink                           in_i,
  otl_out_if.source                        out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [otl_pkg::APB_AW-1:0]  paddr,
  input  wire logic [otl_pkg::APB_DW-1:0]  pwdata,
  output logic [otl_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);

  localparam int D = otl_pkg::LIST_DEPTH;

  // ---------------------------------------------------------------------------
  // Configuration: one register, add_order, at word 0.
  // ---------------------------------------------------------------------------
  logic [otl_pkg::ORDER_W-1:0] order_q, order_d;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[otl_pkg::APB_AW-1:2] == otl_pkg::REG_ADD_ORDER);
  assign prdata  = reg_sel ? otl_pkg::APB_DW'(order_q) : '0;

  always_comb begin
    order_d = order_q;
    if (psel && penable && pwrite && reg_sel) begin
      order_d = pwdata[otl_pkg::ORDER_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: take an item while the result slot is free or being taken.
  // ---------------------------------------------------------------------------
  logic in_acc;
  logic out_valid_q, out_valid_d;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------------
  // List state held at the top: count and the current target.
  // ---------------------------------------------------------------------------
  logic [otl_pkg::CNT_W-1:0]    count_q, count_d;
  logic [otl_pkg::ID_WIDTH-1:0] cur_id_q, cur_id_d;
  logic                         cur_valid_q, cur_valid_d;
  logic                         full;
  logic                         ovf;
  otl_pkg::cmd_t                cmd;

  assign full = (count_q == otl_pkg::CNT_W'(D));

  // Build the command the cells see; no accepted item means no change.
  always_comb begin
    cmd.op       = otl_pkg::OP_NONE;
    cmd.order    = order_q;
    cmd.item.id  = in_i.entity_id;
    cmd.item.key = in_i.strength;
    cmd.count    = count_q;
    ovf          = 1'b0;
    if (in_acc) begin
      unique case (in_i.func)
        otl_pkg::FUNC_ENTER: begin
          if (full) begin
            ovf = 1'b1;
          end else begin
            cmd.op = otl_pkg::OP_INSERT;
          end
        end
        otl_pkg::FUNC_EXIT: cmd.op = otl_pkg::OP_REMOVE;
        otl_pkg::FUNC_UPDATE: begin
          // drop the killed target first, if there is one
          if (in_i.killed && cur_valid_q) begin
            cmd.op      = otl_pkg::OP_REMOVE;
            cmd.item.id = cur_id_q;
          end
        end
        default: cmd.op = otl_pkg::OP_NONE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain: the hit flag ripples front to back; inserts shift toward the
  // back, removals pull toward the front.
  // ---------------------------------------------------------------------------
  otl_pkg::entry_t entry_q [D];
  otl_pkg::entry_t entry_d [D];
  logic [D:0]      seen;

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    otl_pkg::entry_t left_n;
    otl_pkg::entry_t right_n;

    if (i == 0) begin : g_front
      assign left_n = cmd.item;
    end else begin : g_mid_l
      assign left_n = entry_q[i-1];
    end

    if (i == D - 1) begin : g_back
      assign right_n = entry_q[i];
    end else begin : g_mid_r
      assign right_n = entry_q[i+1];
    end

    otl_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (otl_pkg::IDX_W'(i)),
      .cmd_i     (cmd),
      .seen_i    (seen[i]),
      .left_i    (left_n),
      .right_i   (right_n),
      .seen_o    (seen[i+1]),
      .entry_q_o (entry_q[i]),
      .entry_d_o (entry_d[i])
    );
  end

  // Hit anywhere along the chain means the list grew or shrank by one.
  always_comb begin
    count_d = count_q;
    if (seen[D]) begin
      if (cmd.op == otl_pkg::OP_INSERT) begin
        count_d = count_q + otl_pkg::CNT_W'(1);
      end else if (cmd.op == otl_pkg::OP_REMOVE) begin
        count_d = count_q - otl_pkg::CNT_W'(1);
      end
    end
  end

  // Update re-reads the front after any removal of this cycle.
  always_comb begin
    cur_id_d    = cur_id_q;
    cur_valid_d = cur_valid_q;
    if (in_acc && (in_i.func == otl_pkg::FUNC_UPDATE)) begin
      cur_valid_d = (count_d != '0);
      cur_id_d    = (count_d != '0) ? entry_d[0].id : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: report the list as it stands after the item.
  // ---------------------------------------------------------------------------
  logic                         tvalid_q;
  logic [otl_pkg::ID_WIDTH-1:0] tid_q;
  logic [otl_pkg::CNT_W-1:0]    rcnt_q;
  logic                         ovf_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= otl_pkg::ORDER_APPEND;
      count_q     <= '0;
      cur_id_q    <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      order_q     <= order_d;
      count_q     <= count_d;
      cur_id_q    <= cur_id_d;
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tvalid_q <= (count_d != '0);
      tid_q    <= (count_d != '0) ? entry_d[0].id : '0;
      rcnt_q   <= count_d;
      ovf_q    <= ovf;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.target_valid = tvalid_q;
  assign out_o.target_id    = tid_q;
  assign out_o.entry_count  = rcnt_q;
  assign out_o.overflow     = ovf_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= otl_pkg::CNT_W'(D))
    else $error("entry count above list depth");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> count_q == $past(count_q))
    else $error("entry count moved without an item");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ovf_q) |-> (rcnt_q == otl_pkg::CNT_W'(D)))
    else $error("overflow reported on a list that is not full");

  a_tvalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (tvalid_q == (rcnt_q != '0)))
    else $error("target valid disagrees with entry count");

  a_cur_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cur_valid_q |-> (cur_id_q == '0))
    else $error("current target set without a valid target");

endmodule

`default_nettype wire
